[rtl/core/mwlfo_pkg.sv]
// Shared codes, constants and the sine table generator for the LFO core.
package mwlfo_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Waveform shape codes.
    localparam logic [2:0] SHAPE_SINE       = 3'd0;
    localparam logic [2:0] SHAPE_COSINE     = 3'd1;
    localparam logic [2:0] SHAPE_NEG_COSINE = 3'd2;
    localparam logic [2:0] SHAPE_SAW_UP     = 3'd3;
    localparam logic [2:0] SHAPE_SAW_DOWN   = 3'd4;
    localparam logic [2:0] SHAPE_SQUARE     = 3'd5;
    localparam logic [2:0] SHAPE_INV_SQUARE = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WAVE_SHAPE = 2'd0;
    localparam logic [1:0] CFG_PHASE_STEP = 2'd1;

    // Result queue geometry (depth is a power of two).
    localparam int OUT_FIFO_DEPTH     = 4;
    localparam int OUT_FIFO_PTR_BITS  = 2;
    localparam int OUT_FIFO_CNT_BITS  = 3;

    // Pi/2 in Q30 and the Taylor series divisors (n+1)(n+2) for odd n.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

    // One quarter-wave sine entry, evaluated at elaboration time only.
    function automatic logic [63:0] sine_entry(input int unsigned k,
                                               input int unsigned tbits,
                                               input int unsigned obits);
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        logic [63:0]        vmax;
        a    = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (tbits + 1);
        a2   = (a * a) >> 30;
        term = a;
        sum  = '0;
        for (int i = 0; i < 8; i++) begin
            if ((i % 2) == 0) begin
                sum = sum + $signed(term);
            end else begin
                sum = sum - $signed(term);
            end
            term = ((term * a2) >> 30) / TAYLOR_DIV[i];
        end
        if (sum < 0) begin
            sum = '0;
        end
        vmax = (64'd1 << (obits - 1)) - 64'd1;
        v    = (($unsigned(sum) << (obits - 1)) + (64'd1 << 29)) >> 30;
        if (v > vmax) begin
            v = vmax;
        end
        return v;
    endfunction

endpackage

[rtl/core/mwlfo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mwlfo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read at the written entry sees old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mwlfo_sine_rom.sv]
// Quarter-wave sine ROM with registered read data.
module mwlfo_sine_rom #(
    parameter int TABLE_BITS  = 10,
    parameter int OUTPUT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic [TABLE_BITS-1:0]  i_addr,
    output logic [OUTPUT_BITS-2:0] o_data
);
    import mwlfo_pkg::*;

    localparam int TABLE_SIZE = 1 << TABLE_BITS;

    logic [OUTPUT_BITS-2:0] w_table [TABLE_SIZE];
    logic [OUTPUT_BITS-2:0] r_data;

    // Table contents are constants worked out at elaboration.
    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_entry
        assign w_table[k] = (OUTPUT_BITS-1)'(sine_entry(k, TABLE_BITS, OUTPUT_BITS));
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_table[i_addr];
    end

    assign o_data = r_data;

endmodule

[rtl/core/mwlfo_out_fifo.sv]
// Small result queue that decouples the pipeline from the output handshake.
module mwlfo_out_fifo #(
    parameter int WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_push,
    input  logic [WIDTH-1:0]                        i_data,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [WIDTH-1:0]                        o_data,
    output logic [mwlfo_pkg::OUT_FIFO_CNT_BITS-1:0] o_count
);
    import mwlfo_pkg::*;

    logic [WIDTH-1:0]             r_mem [OUT_FIFO_DEPTH];
    logic [OUT_FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [OUT_FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [OUT_FIFO_CNT_BITS-1:0] r_count;
    logic                         w_pop;

    assign w_pop   = o_valid & i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Pointer and fill count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Word storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/core/multi_waveform_lfo_core.sv]
// Multi-waveform LFO: phase accumulator in RAM, sine ROM and result queue.
// The oscillator takes one item per cycle while o_ready is high. An accepted
// item reads the phase word from a one-entry RAM, the next stage updates and
// writes it back (a forwarding register covers back-to-back items), and a
// sample item also reads the quarter-wave sine ROM in that stage; the
// registered ROM data and the stage 2 registers form its result, which is
// pushed into the result queue and offered on the output from there. Results
// wait in a four-word queue; the input is held off only when that queue and
// the words in flight would overfill it. Configuration words are taken every
// cycle and must be written while no item is in progress.
module multi_waveform_lfo_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int OUTPUT_BITS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [31:0]                   i_advance_amount,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [OUTPUT_BITS-1:0] o_wave_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import mwlfo_pkg::*;

    localparam logic [PHASE_BITS-1:0] HALF_TURN    = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [PHASE_BITS-1:0] QUARTER_TURN = {2'b01, {(PHASE_BITS-2){1'b0}}};
    localparam logic [OUTPUT_BITS-1:0] OUT_MAX = {1'b0, {(OUTPUT_BITS-1){1'b1}}};
    localparam logic [OUTPUT_BITS-1:0] OUT_MIN = {1'b1, {(OUTPUT_BITS-1){1'b0}}};

    // Configuration registers.
    logic [2:0]  r_wave_shape;
    logic [31:0] r_phase_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape <= SHAPE_SINE;
            r_phase_step <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WAVE_SHAPE: r_wave_shape <= i_cfg_data[2:0];
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                default:        r_wave_shape <= r_wave_shape;
            endcase
        end
    end

    // Input acceptance: room in the queue for every sample word in flight.
    logic                         w_accept;
    logic [OUT_FIFO_CNT_BITS-1:0] w_fifo_count;
    logic [OUT_FIFO_CNT_BITS:0]   w_pending;
    logic                         r_s1_valid;
    logic [1:0]                   r_s1_op;
    logic [PHASE_BITS-1:0]        r_s1_amount;
    logic                         r_s2_valid;

    assign w_pending = (OUT_FIFO_CNT_BITS+1)'(w_fifo_count)
                     + (OUT_FIFO_CNT_BITS+1)'(r_s1_valid && (r_s1_op == OP_SAMPLE))
                     + (OUT_FIFO_CNT_BITS+1)'(r_s2_valid);
    assign o_ready   = (w_pending < (OUT_FIFO_CNT_BITS+1)'(OUT_FIFO_DEPTH));
    assign w_accept  = i_valid & o_ready;

    // Amounts widened or cut to the phase width.
    logic [PHASE_BITS+31:0] w_amount_ext;
    logic [PHASE_BITS+31:0] w_step_ext;

    assign w_amount_ext = {{PHASE_BITS{1'b0}}, i_advance_amount};
    assign w_step_ext   = {{PHASE_BITS{1'b0}}, r_phase_step};

    // Stage 1 capture; the phase read is issued in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op     <= i_operation;
            r_s1_amount <= w_amount_ext[PHASE_BITS-1:0];
        end
    end

    // Phase store with a written flag and write-to-read forwarding.
    logic                  w_ph_we;
    logic [PHASE_BITS-1:0] w_ph_rdata;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] w_cur_phase;
    logic                  r_ph_init;
    logic                  r_rd_init;
    logic                  r_fwd_valid;
    logic [PHASE_BITS-1:0] r_fwd_phase;

    assign w_ph_we = r_s1_valid;

    mwlfo_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (1)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (w_ph_we),
        .i_waddr (1'b0),
        .i_wdata (n_phase),
        .i_raddr (1'b0),
        .o_rdata (w_ph_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_init   <= 1'b0;
            r_rd_init   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_rd_init   <= r_ph_init;
            r_fwd_valid <= w_ph_we;
            if (w_ph_we) begin
                r_ph_init <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ph_we) begin
            r_fwd_phase <= n_phase;
        end
    end

    assign w_cur_phase = r_fwd_valid ? r_fwd_phase
                       : (r_rd_init ? w_ph_rdata : '0);

    // Phase update for each operation.
    always_comb begin
        case (r_s1_op)
            OP_SAMPLE:  n_phase = w_cur_phase + w_step_ext[PHASE_BITS-1:0];
            OP_ADVANCE: n_phase = w_cur_phase + r_s1_amount;
            OP_CLEAR:   n_phase = '0;
            default:    n_phase = w_cur_phase;
        endcase
    end

    // Lookup angle, quadrant and mirrored table address.
    logic [PHASE_BITS-1:0]      w_angle;
    logic [1:0]                 w_quad;
    logic [SINE_TABLE_BITS-1:0] w_index;
    logic [SINE_TABLE_BITS-1:0] w_rom_addr;
    logic [OUTPUT_BITS-2:0]     w_rom_data;

    always_comb begin
        case (r_wave_shape)
            SHAPE_COSINE:     w_angle = w_cur_phase - QUARTER_TURN;
            SHAPE_NEG_COSINE: w_angle = w_cur_phase + QUARTER_TURN;
            default:          w_angle = w_cur_phase ^ HALF_TURN;
        endcase
    end

    assign w_quad     = w_angle[PHASE_BITS-1 -: 2];
    assign w_index    = w_angle[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign w_rom_addr = w_quad[0] ? ~w_index : w_index;

    mwlfo_sine_rom #(
        .TABLE_BITS  (SINE_TABLE_BITS),
        .OUTPUT_BITS (OUTPUT_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // Saw value: top output bits of the phase shifted by a half turn.
    logic [PHASE_BITS+OUTPUT_BITS-1:0] w_saw_ext;

    assign w_saw_ext = {w_cur_phase ^ HALF_TURN, {OUTPUT_BITS{1'b0}}};

    // Stage 2 registers, aligned with the ROM read data.
    logic [2:0]             r_s2_shape;
    logic                   r_s2_neg;
    logic                   r_s2_low;
    logic [OUTPUT_BITS-1:0] r_s2_saw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && (r_s1_op == OP_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_shape <= r_wave_shape;
        r_s2_neg   <= w_quad[1];
        r_s2_low   <= ~w_cur_phase[PHASE_BITS-1];
        r_s2_saw   <= w_saw_ext[PHASE_BITS+OUTPUT_BITS-1 -: OUTPUT_BITS];
    end

    // Result selection by shape.
    logic [OUTPUT_BITS-1:0] w_rom_ext;
    logic [OUTPUT_BITS-1:0] w_value;

    assign w_rom_ext = {1'b0, w_rom_data};

    always_comb begin
        case (r_s2_shape)
            SHAPE_SINE,
            SHAPE_COSINE,
            SHAPE_NEG_COSINE: w_value = r_s2_neg ? (~w_rom_ext + 1'b1) : w_rom_ext;
            SHAPE_SAW_UP:     w_value = r_s2_saw;
            SHAPE_SAW_DOWN:   w_value = (r_s2_saw == OUT_MIN) ? OUT_MAX
                                                              : (~r_s2_saw + 1'b1);
            SHAPE_SQUARE:     w_value = r_s2_low ? OUT_MIN : OUT_MAX;
            SHAPE_INV_SQUARE: w_value = r_s2_low ? OUT_MAX : OUT_MIN;
            default:          w_value = '0;
        endcase
    end

    // Result queue toward the output channel.
    logic [OUTPUT_BITS-1:0] w_out_data;

    mwlfo_out_fifo #(
        .WIDTH (OUTPUT_BITS)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (w_value),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out_data),
        .o_count (w_fifo_count)
    );

    assign o_wave_value = $signed(w_out_data);

endmodule
